FILE: hw/rtl/ppd_pkg.sv
// Shared types, constants and decode tables for the poll packet decoder.
package ppd_pkg;

	// Default store depth and limits
	localparam int PACKET_DEPTH_DEF = 16;
	localparam int COUNT_W          = 9;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;
	localparam logic [COUNT_W-1:0] MACRO_LEN = 9'd3;

	// Positions inside a poll packet
	localparam int HDR_POS_LEN   = 1;
	localparam int HDR_POS_MASK  = 2;
	localparam int DATA_POS_FIRST = 3;
	localparam int MASK_BITS     = 8;

	// Configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam logic [2:0] REG_POLL     = 3'd0;
	localparam logic [2:0] REG_POLL_ACK = 3'd1;
	localparam logic [2:0] REG_MACRO    = 3'd2;
	localparam logic [2:0] REG_PF_POLL  = 3'd3;
	localparam logic [2:0] REG_PF_ACK   = 3'd4;

	// Register reset values
	localparam logic [7:0] POLL_RST     = 8'h5A;
	localparam logic [7:0] POLL_ACK_RST = 8'hC3;
	localparam logic [7:0] MACRO_RST    = 8'h5B;
	localparam logic [7:0] PF_POLL_RST  = 8'hA5;
	localparam logic [7:0] PF_ACK_RST   = 8'h9B;

	typedef struct packed {
		logic [7:0] poll_code;
		logic [7:0] poll_ack_code;
		logic [7:0] macro_poll_code;
		logic [7:0] power_fail_poll_code;
		logic [7:0] power_fail_ack_code;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic step;      // take the offered byte
		logic rd_first;  // read first data byte
		logic advance;   // event taken, read the next one
		logic show_ack;
		logic show_evt;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic ack;   // offered byte is answered with an ack
		logic evt;   // offered byte completes a packet with events
		logic last;  // current event is the final one
	} status_t;

	// Inverse house / unit table
	function automatic logic [3:0] inv_house(input logic [3:0] nib);
		logic [3:0] r;
		case (nib)
			4'd0:    r = 4'd12;
			4'd1:    r = 4'd4;
			4'd2:    r = 4'd2;
			4'd3:    r = 4'd10;
			4'd4:    r = 4'd14;
			4'd5:    r = 4'd6;
			4'd6:    r = 4'd0;
			4'd7:    r = 4'd8;
			4'd8:    r = 4'd13;
			4'd9:    r = 4'd5;
			4'd10:   r = 4'd3;
			4'd11:   r = 4'd11;
			4'd12:   r = 4'd15;
			4'd13:   r = 4'd7;
			4'd14:   r = 4'd1;
			default: r = 4'd9;
		endcase
		return r;
	endfunction

	// Inverse function table
	function automatic logic [3:0] inv_func(input logic [3:0] nib);
		logic [3:0] r;
		case (nib)
			4'd9:    r = 4'd15;
			4'd11:   r = 4'd9;
			4'd12:   r = 4'd11;
			4'd13:   r = 4'd12;
			4'd14:   r = 4'd13;
			4'd15:   r = 4'd14;
			default: r = nib;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/ppd_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
module ppd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/ppd_datapath.sv
// Byte counter, packet header, packet store and event decode.
module ppd_datapath #(
	parameter int PACKET_DEPTH = ppd_pkg::PACKET_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ppd_pkg::cfg_t    cfg,
	input  ppd_pkg::cmd_t    cmd,
	output ppd_pkg::status_t st,
	input  logic [7:0]       rx_byte,
	output logic             out_kind,
	output logic [7:0]       tx_byte,
	output logic [3:0]       house_index,
	output logic             is_function,
	output logic [3:0]       code_index,
	output logic             last
);

	localparam int AW = $clog2(PACKET_DEPTH);
	localparam int CW = ppd_pkg::COUNT_W;

	logic [CW-1:0] count_q;
	logic          macro_q;
	logic [7:0]    hdr0_q;
	logic [7:0]    len_q;
	logic [7:0]    mask_q;
	logic [7:0]    ack_q;
	logic [AW-1:0] pos_q;
	logic [AW-1:0] last_pos_q;

	logic          hit_poll, hit_macro, hit_pf;
	logic [CW-1:0] base;
	logic          in_store;
	logic [CW-1:0] cnt1;
	logic          macro_nx;
	logic [7:0]    len_eff;
	logic          done;
	logic [3:0]    nib;
	logic [AW:0]   lp_full;
	logic [AW:0]   lp;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    rdata;
	logic [AW-1:0] idx;
	logic          isf;
	logic [3:0]    house;
	logic [3:0]    code;

	// Poll code match, with priority poll > macro > power fail
	always_comb begin
		hit_poll  = (rx_byte == cfg.poll_code);
		hit_macro = !hit_poll && (rx_byte == cfg.macro_poll_code);
		hit_pf    = !hit_poll && !hit_macro && (rx_byte == cfg.power_fail_poll_code);
	end

	// Count after this byte, and packet completion check
	always_comb begin
		base     = (hit_poll || hit_macro || hit_pf) ? '0 : count_q;
		in_store = (base < CW'(PACKET_DEPTH));
		cnt1     = (base < ppd_pkg::COUNT_MAX) ? base + 9'd1 : base;
		macro_nx = macro_q || hit_macro;
		len_eff  = (base == CW'(ppd_pkg::HDR_POS_LEN)) ? rx_byte : len_q;
		done     = !macro_nx && (cnt1 > 9'd1) && (hdr0_q == cfg.poll_code) &&
		           ({1'b0, cnt1} >= ({2'b00, len_eff} + 10'd2));
		nib      = len_eff[3:0];
		lp_full  = (AW+1)'(nib) + (AW+1)'(1);
		lp       = (lp_full > (AW+1)'(PACKET_DEPTH - 1)) ? (AW+1)'(PACKET_DEPTH - 1) : lp_full;
	end

	assign st.ack  = hit_poll || hit_pf;
	assign st.evt  = done && (nib >= 4'd2);
	assign st.last = (pos_q == last_pos_q);

	// Counter and macro mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			macro_q <= 1'b0;
		end else if (cmd.step) begin
			if (macro_nx) begin
				count_q <= (cnt1 == ppd_pkg::MACRO_LEN) ? '0 : cnt1;
				macro_q <= (cnt1 != ppd_pkg::MACRO_LEN);
			end else begin
				count_q <= done ? '0 : cnt1;
				macro_q <= 1'b0;
			end
		end
	end

	// Header copies, ack byte and event walk position
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			if (base == '0) begin
				hdr0_q <= rx_byte;
			end
			if (base == CW'(ppd_pkg::HDR_POS_LEN)) begin
				len_q <= rx_byte;
			end
			if (base == CW'(ppd_pkg::HDR_POS_MASK)) begin
				mask_q <= rx_byte;
			end
			ack_q <= hit_poll ? cfg.poll_ack_code : cfg.power_fail_ack_code;
			if (st.evt) begin
				pos_q      <= AW'(ppd_pkg::DATA_POS_FIRST);
				last_pos_q <= lp[AW-1:0];
			end
		end else if (cmd.advance) begin
			pos_q <= pos_q + AW'(1);
		end
	end

	// Packet store
	assign ram_re    = cmd.rd_first || cmd.advance;
	assign ram_raddr = cmd.advance ? pos_q + AW'(1) : pos_q;

	ppd_ram #(
		.WIDTH(8),
		.DEPTH(PACKET_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.step && in_store),
		.waddr (base[AW-1:0]),
		.wdata (rx_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	// Event decode from the byte just read
	always_comb begin
		idx   = pos_q - AW'(ppd_pkg::DATA_POS_FIRST);
		isf   = (idx < AW'(ppd_pkg::MASK_BITS)) ? mask_q[idx[2:0]] : 1'b0;
		house = ppd_pkg::inv_house(rdata[7:4]);
		code  = isf ? ppd_pkg::inv_func(rdata[3:0]) : ppd_pkg::inv_house(rdata[3:0]);
	end

	// Result fields
	always_comb begin
		out_kind    = cmd.show_evt;
		tx_byte     = cmd.show_ack ? ack_q : 8'd0;
		house_index = cmd.show_evt ? house : 4'd0;
		is_function = cmd.show_evt ? isf : 1'b0;
		code_index  = cmd.show_evt ? code : 4'd0;
		last        = cmd.show_ack || (cmd.show_evt && st.last);
	end

endmodule

FILE: hw/rtl/ppd_ctrl.sv
// Request sequencing: take a byte, then present its ack or walk its events.
module ppd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rx_valid,
	output logic             rx_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  ppd_pkg::status_t st,
	output ppd_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ACK  = 4'b0010,
		ST_RD   = 4'b0100,
		ST_EVT  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		rx_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				rx_ready = 1'b1;
				if (rx_valid) begin
					cmd.step = 1'b1;
					if (st.ack) begin
						state_d = ST_ACK;
					end else if (st.evt) begin
						state_d = ST_RD;
					end
				end
			end
			ST_ACK: begin
				out_valid    = 1'b1;
				cmd.show_ack = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			ST_RD: begin
				cmd.rd_first = 1'b1;
				state_d      = ST_EVT;
			end
			ST_EVT: begin
				out_valid    = 1'b1;
				cmd.show_evt = 1'b1;
				if (out_ready) begin
					if (st.last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.advance = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hw/rtl/powerline_poll_packet_decoder_unit.sv
// Channel   | Handshake             | Request payload
// ----------+-----------------------+-------------------------------------------------
// rx        | rx_valid / rx_ready   | rx_byte
// out       | out_valid / out_ready | out_kind, tx_byte, house_index, is_function,
//           |                       | code_index, last
// cfg       | psel/penable/pready   | paddr, pwrite, pwdata, prdata
//
// A poll byte shows its ack on the next cycle. A byte that completes a packet
// with events first passes through a store read state, then gives one event per
// cycle while out_ready is high; the single read port of the packet store sets
// that pace. Reset clears the count, macro mode and the controller; the store is
// not cleared. rx_ready is low while any result of the previous byte is pending,
// and out_ready low holds the result.
module powerline_poll_packet_decoder_unit #(
	parameter int PACKET_DEPTH = ppd_pkg::PACKET_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ppd_pkg::ADDR_W-1:0] paddr,
	input  logic [ppd_pkg::DATA_W-1:0] pwdata,
	output logic [ppd_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       rx_valid,
	output logic                       rx_ready,
	input  logic [7:0]                 rx_byte,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       out_kind,
	output logic [7:0]                 tx_byte,
	output logic [3:0]                 house_index,
	output logic                       is_function,
	output logic [3:0]                 code_index,
	output logic                       last
);

	ppd_pkg::cfg_t    cfg_q;
	ppd_pkg::cmd_t    cmd;
	ppd_pkg::status_t st;
	logic             wr_en;
	logic [7:0]       rd_val;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// Code registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poll_code            <= ppd_pkg::POLL_RST;
			cfg_q.poll_ack_code        <= ppd_pkg::POLL_ACK_RST;
			cfg_q.macro_poll_code      <= ppd_pkg::MACRO_RST;
			cfg_q.power_fail_poll_code <= ppd_pkg::PF_POLL_RST;
			cfg_q.power_fail_ack_code  <= ppd_pkg::PF_ACK_RST;
		end else if (wr_en) begin
			case (paddr[4:2])
				ppd_pkg::REG_POLL:     cfg_q.poll_code            <= pwdata[7:0];
				ppd_pkg::REG_POLL_ACK: cfg_q.poll_ack_code        <= pwdata[7:0];
				ppd_pkg::REG_MACRO:    cfg_q.macro_poll_code      <= pwdata[7:0];
				ppd_pkg::REG_PF_POLL:  cfg_q.power_fail_poll_code <= pwdata[7:0];
				ppd_pkg::REG_PF_ACK:   cfg_q.power_fail_ack_code  <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (paddr[4:2])
			ppd_pkg::REG_POLL:     rd_val = cfg_q.poll_code;
			ppd_pkg::REG_POLL_ACK: rd_val = cfg_q.poll_ack_code;
			ppd_pkg::REG_MACRO:    rd_val = cfg_q.macro_poll_code;
			ppd_pkg::REG_PF_POLL:  rd_val = cfg_q.power_fail_poll_code;
			ppd_pkg::REG_PF_ACK:   rd_val = cfg_q.power_fail_ack_code;
			default:               rd_val = 8'd0;
		endcase
		prdata = {{(ppd_pkg::DATA_W-8){1'b0}}, rd_val};
	end

	ppd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_ready  (rx_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	ppd_datapath #(
		.PACKET_DEPTH(PACKET_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.st          (st),
		.rx_byte     (rx_byte),
		.out_kind    (out_kind),
		.tx_byte     (tx_byte),
		.house_index (house_index),
		.is_function (is_function),
		.code_index  (code_index),
		.last        (last)
	);

	// An ack is always a single, final request
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_kind |-> last)
		else $error("ack request without last");

	// One byte at a time: no new byte while a result is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		!(rx_ready && out_valid))
		else $error("input open while a result is pending");

	// After the final result is taken the block is ready again
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> rx_ready)
		else $error("not ready after final result");

	// An event walk never restarts on its own: an event follows an event or a read
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind && !$past(out_valid && out_kind) |-> $past(!rx_ready && !out_valid))
		else $error("event shown without store read");

endmodule
